// ----- src/rsmp_pkg.sv -----
// Shared types and constants for the linear interpolation resampler.
// Used by the sequencer, the output buffer and the top level; no dependencies.
package rsmp_pkg;

	// Most results one item may produce.
	localparam int MAX_RES = 64;
	localparam int CNT_W = $clog2(MAX_RES + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_INTERP,
		ST_TAIL,
		ST_FLUSH
	} rsmp_state_t;

	// Sequencer to output buffer.
	typedef struct packed {
		logic gen;
		logic flush;
		logic run_end;
	} rsmp_ctrl_t;

	// Output buffer to sequencer.
	typedef struct packed {
		logic gen_ok;
		logic flush_ok;
	} rsmp_stat_t;

endpackage

// ----- src/rsmp_in_if.sv -----
// Input channel of the resampler: valid/ready handshake with one source sample.
// No dependencies.
interface rsmp_in_if #(
	parameter int SAMPLE_BITS = 24
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] in_sample;
	logic                          in_last;

	modport source(output valid, in_sample, in_last, input ready);
	modport sink(input valid, in_sample, in_last, output ready);
endinterface

// ----- src/rsmp_out_if.sv -----
// Output channel of the resampler: valid/ready handshake with one result.
// No dependencies.
interface rsmp_out_if #(
	parameter int SAMPLE_BITS = 24
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] out_sample;
	logic                          out_valid;
	logic                          out_last;

	modport source(output valid, out_sample, out_valid, out_last, input ready);
	modport sink(input valid, out_sample, out_valid, out_last, output ready);
endinterface

// ----- src/rsmp_mac.sv -----
// Shared multiply-add unit: base + floor(diff * frac / 2^FRAC_BITS).
// Standalone; driven by the sequencer registers.
module rsmp_mac #(
	parameter int SAMPLE_BITS = 24,
	parameter int FRAC_BITS   = 16
) (
	input  logic signed [SAMPLE_BITS:0]   diff,
	input  logic        [FRAC_BITS:0]     frac,
	input  logic signed [SAMPLE_BITS-1:0] base,
	output logic signed [SAMPLE_BITS-1:0] result
);
	localparam int PROD_W = SAMPLE_BITS + FRAC_BITS + 3;

	logic signed [PROD_W-1:0] prod;
	logic signed [PROD_W-1:0] scaled;
	logic signed [PROD_W-1:0] sum;

	always_comb begin
		prod   = PROD_W'(diff) * PROD_W'($signed({1'b0, frac}));
		// Arithmetic shift gives the floor for negative products.
		scaled = prod >>> FRAC_BITS;
		sum    = scaled + PROD_W'(base);
		result = sum[SAMPLE_BITS-1:0];
	end
endmodule

// ----- src/rsmp_obuf.sv -----
// Output buffer: one pending result plus the output register of the result channel.
// Depends on rsmp_pkg and rsmp_out_if.
module rsmp_obuf import rsmp_pkg::*; #(
	parameter int SAMPLE_BITS = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rsmp_ctrl_t                    ctrl,
	input  logic signed [SAMPLE_BITS-1:0] result,
	output rsmp_stat_t                    stat,
	rsmp_out_if.source                    out_ch
);
	logic                          pend_full_q;
	logic signed [SAMPLE_BITS-1:0] pend_sample_q;
	logic                          out_vld_q;
	logic signed [SAMPLE_BITS-1:0] out_sample_q;
	logic                          out_flag_q;
	logic                          out_last_q;
	logic                          out_free;

	assign out_free      = !out_vld_q || out_ch.ready;
	assign stat.gen_ok   = !pend_full_q || out_free;
	assign stat.flush_ok = out_free;

	assign out_ch.valid      = out_vld_q;
	assign out_ch.out_sample = out_sample_q;
	assign out_ch.out_valid  = out_flag_q;
	assign out_ch.out_last   = out_last_q;

	// A result is held back one step so that the final one of a run can be
	// flagged once the sequencer knows nothing follows it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_full_q   <= 1'b0;
			pend_sample_q <= '0;
			out_vld_q     <= 1'b0;
			out_sample_q  <= '0;
			out_flag_q    <= 1'b0;
			out_last_q    <= 1'b0;
		end else begin
			if (out_vld_q && out_ch.ready) begin
				out_vld_q <= 1'b0;
			end
			if (ctrl.gen) begin
				if (pend_full_q) begin
					out_vld_q    <= 1'b1;
					out_sample_q <= pend_sample_q;
					out_flag_q   <= 1'b1;
					out_last_q   <= 1'b0;
				end
				pend_sample_q <= result;
				pend_full_q   <= 1'b1;
			end else if (ctrl.flush) begin
				if (pend_full_q) begin
					out_vld_q    <= 1'b1;
					out_sample_q <= pend_sample_q;
					out_flag_q   <= 1'b1;
					out_last_q   <= ctrl.run_end;
					pend_full_q  <= 1'b0;
				end else if (ctrl.run_end) begin
					out_vld_q    <= 1'b1;
					out_sample_q <= '0;
					out_flag_q   <= 1'b0;
					out_last_q   <= 1'b1;
				end
			end
		end
	end
endmodule

// ----- src/rsmp_seq.sv -----
// Sequencer: phase accumulator, result counter and run state, stepping the
// shared multiply-add unit once per result. Depends on rsmp_pkg and rsmp_in_if.
module rsmp_seq import rsmp_pkg::*; #(
	parameter int SAMPLE_BITS = 24,
	parameter int FRAC_BITS   = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	rsmp_in_if.sink                       in_ch,
	input  logic [FRAC_BITS+1:0]          step,
	input  rsmp_stat_t                    stat,
	output rsmp_ctrl_t                    ctrl,
	output logic signed [SAMPLE_BITS:0]   diff,
	output logic [FRAC_BITS:0]            frac,
	output logic signed [SAMPLE_BITS-1:0] held
);
	localparam int PW = FRAC_BITS + 3;
	localparam logic [PW-1:0] ONE_Q = {2'b00, 1'b1, {FRAC_BITS{1'b0}}};

	rsmp_state_t                   state_q, state_d;
	logic [PW-1:0]                 phase_q;
	logic [PW-1:0]                 step_q;
	logic [CNT_W-1:0]              cnt_q;
	logic                          last_q;
	logic                          started_q;
	logic signed [SAMPLE_BITS-1:0] held_q;
	logic signed [SAMPLE_BITS-1:0] smp_q;
	logic signed [SAMPLE_BITS:0]   diff_q;

	logic          accept;
	logic          room;
	logic          interp_go;
	logic          tail_go;
	logic [PW:0]   tail_pos;
	logic [PW-1:0] phase_step;
	logic [PW-1:0] phase_wrap;

	always_comb begin
		accept     = (state_q == ST_IDLE) && in_ch.valid;
		room       = cnt_q < CNT_W'(MAX_RES);
		interp_go  = (phase_q < ONE_Q) && room;
		// Tail continues while position + step/2 <= 1, compared at twice the scale.
		tail_pos   = {phase_q, 1'b0} + {1'b0, step_q};
		tail_go    = (tail_pos <= {ONE_Q, 1'b0}) && room;
		phase_step = phase_q + step_q;
		phase_wrap = (phase_q >= ONE_Q) ? phase_q - ONE_Q : '0;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_ch.valid) begin
					if (!started_q) begin
						state_d = in_ch.in_last ? ST_TAIL : ST_IDLE;
					end else begin
						state_d = ST_INTERP;
					end
				end
			end
			ST_INTERP: begin
				if (!interp_go) begin
					state_d = last_q ? ST_TAIL : ST_FLUSH;
				end
			end
			ST_TAIL: begin
				if (!tail_go) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				if (stat.flush_ok) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ch.ready  = 1'b0;
		ctrl.gen     = 1'b0;
		ctrl.flush   = 1'b0;
		ctrl.run_end = last_q;
		case (state_q)
			ST_IDLE:   in_ch.ready = 1'b1;
			ST_INTERP: ctrl.gen = interp_go && stat.gen_ok;
			ST_TAIL:   ctrl.gen = tail_go && stat.gen_ok;
			ST_FLUSH:  ctrl.flush = stat.flush_ok;
			default:   ctrl.gen = 1'b0;
		endcase
	end

	assign diff = diff_q;
	assign frac = phase_q[FRAC_BITS:0];
	assign held = held_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			phase_q   <= '0;
			step_q    <= '0;
			cnt_q     <= '0;
			last_q    <= 1'b0;
			started_q <= 1'b0;
			held_q    <= '0;
			smp_q     <= '0;
			diff_q    <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				step_q <= PW'(step);
				last_q <= in_ch.in_last;
				cnt_q  <= '0;
				smp_q  <= in_ch.in_sample;
				if (!started_q) begin
					held_q    <= in_ch.in_sample;
					phase_q   <= '0;
					started_q <= 1'b1;
					diff_q    <= '0;
				end else begin
					diff_q <= (SAMPLE_BITS+1)'(in_ch.in_sample) - (SAMPLE_BITS+1)'(held_q);
				end
			end
			if (ctrl.gen) begin
				phase_q <= phase_step;
				cnt_q   <= cnt_q + 1'b1;
			end
			if (state_q == ST_INTERP && !interp_go) begin
				// The tail repeats the held sample, so the unit sees a zero slope.
				phase_q <= phase_wrap;
				held_q  <= smp_q;
				diff_q  <= '0;
			end
			if (ctrl.flush && last_q) begin
				held_q    <= '0;
				phase_q   <= '0;
				started_q <= 1'b0;
			end
		end
	end
endmodule

// ----- src/linear_interp_resampler.sv -----
// Linear interpolation resampler: top level with the step register and its clamp.
// Depends on rsmp_pkg, rsmp_in_if, rsmp_out_if, rsmp_mac, rsmp_obuf and rsmp_seq.
//
// One channel of signed samples streams in; results lie at multiples of phase_step
// (source rate over target rate, unsigned fixed point with FRAC_BITS fraction bits,
// clamped to 1/32 .. 2). Each sample yields the outputs between it and the previous
// sample; the last sample of a run adds held repeats so the run gives round(N/step)
// outputs, and a final item that yields nothing gives one marker result with
// out_valid low. out_last flags the final result of a run. A single multiply-add
// unit makes one result per cycle while the result channel does not stall, and an
// item produces at most 64 results. The first item of a run only loads the held
// sample, unless it is also the last. The input is not ready while an item is being
// worked on.
module linear_interp_resampler import rsmp_pkg::*; #(
	parameter int SAMPLE_BITS = 24,
	parameter int FRAC_BITS   = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	rsmp_in_if.sink              in_ch,
	rsmp_out_if.source           out_ch,
	input  logic                 cfg_we,
	input  logic [FRAC_BITS+1:0] cfg_wdata
);
	localparam int SW = FRAC_BITS + 2;
	localparam logic [SW-1:0] STEP_ONE = {2'b01, {FRAC_BITS{1'b0}}};
	localparam logic [SW-1:0] STEP_MIN = STEP_ONE >> 5;
	localparam logic [SW-1:0] STEP_MAX = {2'b10, {FRAC_BITS{1'b0}}};

	logic [SW-1:0]                 phase_step_q;
	logic [SW-1:0]                 step_clamped;
	rsmp_ctrl_t                    ctrl;
	rsmp_stat_t                    stat;
	logic signed [SAMPLE_BITS:0]   diff;
	logic [FRAC_BITS:0]            frac;
	logic signed [SAMPLE_BITS-1:0] held;
	logic signed [SAMPLE_BITS-1:0] result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_step_q <= STEP_ONE;
		end else if (cfg_we) begin
			phase_step_q <= cfg_wdata;
		end
	end

	always_comb begin
		step_clamped = phase_step_q;
		if (phase_step_q < STEP_MIN) begin
			step_clamped = STEP_MIN;
		end else if (phase_step_q > STEP_MAX) begin
			step_clamped = STEP_MAX;
		end
	end

	rsmp_seq #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.FRAC_BITS  (FRAC_BITS)
	) u_seq (
		.clk   (clk),
		.arst_n(arst_n),
		.in_ch (in_ch),
		.step  (step_clamped),
		.stat  (stat),
		.ctrl  (ctrl),
		.diff  (diff),
		.frac  (frac),
		.held  (held)
	);

	rsmp_mac #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.FRAC_BITS  (FRAC_BITS)
	) u_mac (
		.diff  (diff),
		.frac  (frac),
		.base  (held),
		.result(result)
	);

	rsmp_obuf #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_obuf (
		.clk   (clk),
		.arst_n(arst_n),
		.ctrl  (ctrl),
		.result(result),
		.stat  (stat),
		.out_ch(out_ch)
	);
endmodule
